FILE: rtl/core/apsf_pkg.sv
// Shared types and constants of the Annex B parameter-set filter.
package apsf_pkg;

  localparam int unsigned WIN_DEPTH = 4;
  localparam int unsigned BUF_DEPTH = WIN_DEPTH + 1;
  localparam int unsigned PAD_DEPTH = 9;
  localparam int unsigned MAX_RES   = 5;
  localparam int unsigned Q_DEPTH   = 8;
  localparam int unsigned GRP_CW    = $clog2(MAX_RES + 1);
  localparam int unsigned Q_CW      = $clog2(Q_DEPTH + 1);

  localparam logic [4:0] TYPE_SPS = 5'd7;
  localparam logic [4:0] TYPE_PPS = 5'd8;

  typedef enum logic [1:0] {
    MODE_BEFORE = 2'd0,
    MODE_DROP   = 2'd1,
    MODE_KEEP   = 2'd2
  } mode_t;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       complete;
    logic       last;
  } result_t;

  typedef struct packed {
    result_t [MAX_RES-1:0] item;
    logic [GRP_CW-1:0]     count;
  } res_group_t;

endpackage

FILE: rtl/core/apsf_scan.sv
// Start code scanner, NAL unit selection and lookahead window state.
module apsf_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          data_byte,
  input  logic                end_of_packet,
  output apsf_pkg::res_group_t group
);
  import apsf_pkg::*;

  logic [7:0]  win_r   [WIN_DEPTH];
  logic [7:0]  win_nxt [WIN_DEPTH];
  logic [2:0]  fill_r, fill_nxt;
  logic [2:0]  skip_r, skip_nxt;
  mode_t       mode_r, mode_nxt;
  logic        sps_r, sps_nxt;
  logic        pps_r, pps_nxt;

  logic [7:0]  buf_b [PAD_DEPTH];
  logic [2:0]  n;
  logic [3:0]  nn;
  logic [2:0]  skip;
  mode_t       mode;
  logic        sps, pps;
  logic        go, emit_ok, usable, sc3, sc4;
  logic [7:0]  hdr;
  logic [2:0]  used;
  logic [GRP_CW-1:0] cnt;
  res_group_t  grp;

  always_comb begin
    for (int k = 0; k < PAD_DEPTH; k++) begin
      if (k < BUF_DEPTH && 3'(k) < fill_r) begin
        buf_b[k] = win_r[k % WIN_DEPTH];
      end else if (k < BUF_DEPTH && 3'(k) == fill_r) begin
        buf_b[k] = data_byte;
      end else begin
        buf_b[k] = 8'd0;
      end
    end
    n       = fill_r + 3'd1;
    nn      = {1'b0, n};
    skip    = skip_r;
    mode    = mode_r;
    sps     = sps_r;
    pps     = pps_r;
    go      = 1'b1;
    used    = 3'd0;
    cnt     = '0;
    grp     = '0;
    emit_ok = 1'b0;
    usable  = 1'b0;
    sc3     = 1'b0;
    sc4     = 1'b0;
    hdr     = 8'd0;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      if (go && nn > 4'(i) && (end_of_packet || nn >= 4'(i + 4))) begin
        emit_ok = 1'b1;
        sc3 = nn >= 4'(i + 3) && buf_b[i] == 8'd0 && buf_b[i+1] == 8'd0
              && buf_b[i+2] == 8'd1;
        sc4 = nn >= 4'(i + 4) && buf_b[i] == 8'd0 && buf_b[i+1] == 8'd0
              && buf_b[i+2] == 8'd0 && buf_b[i+3] == 8'd1;
        usable = 1'b0;
        hdr    = 8'd0;
        if (skip != 3'd0) begin
          skip = skip - 3'd1;
        end else if (sc3) begin
          skip   = 3'd3;
          usable = end_of_packet ? (nn >= 4'(i + 5)) : (nn >= 4'(i + 4));
          hdr    = (nn >= 4'(i + 4)) ? buf_b[i+3] : 8'd0;
          if (!usable) begin
            mode = MODE_DROP;
          end else if (hdr[4:0] == TYPE_SPS) begin
            sps  = 1'b1;
            mode = MODE_KEEP;
          end else if (hdr[4:0] == TYPE_PPS) begin
            pps  = 1'b1;
            mode = MODE_KEEP;
          end else begin
            mode = MODE_DROP;
          end
        end else if (sc4) begin
          if (!end_of_packet && nn < 4'(i + 5)) begin
            go      = 1'b0;
            emit_ok = 1'b0;
          end else begin
            skip   = 3'd4;
            usable = !end_of_packet && nn >= 4'(i + 5);
            hdr    = (nn >= 4'(i + 5)) ? buf_b[i+4] : 8'd0;
            if (!usable) begin
              mode = MODE_DROP;
            end else if (hdr[4:0] == TYPE_SPS) begin
              sps  = 1'b1;
              mode = MODE_KEEP;
            end else if (hdr[4:0] == TYPE_PPS) begin
              pps  = 1'b1;
              mode = MODE_KEEP;
            end else begin
              mode = MODE_DROP;
            end
          end
        end
        if (emit_ok) begin
          if (mode == MODE_KEEP) begin
            grp.item[cnt] = '{kind: KIND_BYTE, data: buf_b[i], complete: 1'b0, last: 1'b0};
            cnt = cnt + GRP_CW'(1);
          end
          used = used + 3'd1;
        end
      end else begin
        go = 1'b0;
      end
    end
    if (end_of_packet) begin
      grp.item[cnt] = '{kind: KIND_VERDICT, data: 8'd0, complete: sps && pps, last: 1'b1};
      cnt = cnt + GRP_CW'(1);
    end
    grp.count = cnt;
  end

  always_comb begin
    if (end_of_packet) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win_nxt[k] = 8'd0;
      end
      fill_nxt = 3'd0;
      skip_nxt = 3'd0;
      mode_nxt = MODE_BEFORE;
      sps_nxt  = 1'b0;
      pps_nxt  = 1'b0;
    end else begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win_nxt[k] = buf_b[4'(k) + {1'b0, used}];
      end
      fill_nxt = n - used;
      skip_nxt = skip;
      mode_nxt = mode;
      sps_nxt  = sps;
      pps_nxt  = pps;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win_r[k] <= 8'd0;
      end
      fill_r <= 3'd0;
      skip_r <= 3'd0;
      mode_r <= MODE_BEFORE;
      sps_r  <= 1'b0;
      pps_r  <= 1'b0;
    end else if (step_en) begin
      win_r  <= win_nxt;
      fill_r <= fill_nxt;
      skip_r <= skip_nxt;
      mode_r <= mode_nxt;
      sps_r  <= sps_nxt;
      pps_r  <= pps_nxt;
    end
  end

  assign group = grp;

endmodule

FILE: rtl/core/apsf_outq.sv
// Result queue: takes a group of results per item, hands them out one a cycle while head_ready is high.
module apsf_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  apsf_pkg::res_group_t group,
  output logic                 space_ok,
  output logic                 head_valid,
  input  logic                 head_ready,
  output apsf_pkg::result_t    head
);
  import apsf_pkg::*;

  result_t         q_r   [Q_DEPTH];
  result_t         q_nxt [Q_DEPTH];
  logic [Q_CW-1:0] count_r, count_nxt;
  logic            pop;
  logic [Q_CW-1:0] rem;
  logic [Q_CW-1:0] idx;

  assign pop = (count_r != '0) && head_ready;
  assign rem = count_r - Q_CW'(pop);

  always_comb begin
    idx = '0;
    for (int k = 0; k < Q_DEPTH; k++) begin
      if (pop) begin
        q_nxt[k] = (k < Q_DEPTH - 1) ? q_r[(k + 1) % Q_DEPTH] : '0;
      end else begin
        q_nxt[k] = q_r[k];
      end
      idx = Q_CW'(k) - rem;
      if (push && Q_CW'(k) >= rem && idx < Q_CW'(group.count)) begin
        q_nxt[k] = group.item[idx[GRP_CW-1:0]];
      end
    end
    count_nxt = rem + (push ? Q_CW'(group.count) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign space_ok   = count_r <= Q_CW'(Q_DEPTH - MAX_RES);
  assign head_valid = count_r != '0;
  assign head       = q_r[0];

endmodule

FILE: rtl/core/annexb_parameter_set_filter_core.sv
// The results an item causes are written into the result queue when the item is accepted and leave from its head.
// Throughput: one input item per cycle when the queue has room; each item causes zero to five results,
// which leave through an eight-entry result queue at one per cycle, so the output port sets the pace.
// Input is taken while at least five queue entries are free.
// Reset (rst_n low, synchronous) empties the queue and clears the window and unit state.
module annexb_parameter_set_filter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] sets_complete, [15:9] zero
  output logic        out_tuser,  // [0] item_kind
  output logic        out_tlast
);
  import apsf_pkg::*;

  res_group_t group;
  result_t    head;
  logic       space_ok;
  logic       in_fire;

  assign in_tready = space_ok;
  assign in_fire   = in_tvalid && in_tready;

  apsf_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (in_fire),
    .data_byte     (in_tdata),
    .end_of_packet (in_tlast),
    .group         (group)
  );

  apsf_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .group      (group),
    .space_ok   (space_ok),
    .head_valid (out_tvalid),
    .head_ready (out_tready),
    .head       (head)
  );

  assign out_tdata = {7'd0, head.complete, head.data};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule
